// ===== rtl/core/cqmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqmm_pkg
// Shared types and constants for the circular queue with min/max query.
// ----------------------------------------------------------------------------
package cqmm_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 8;
  localparam int DATA_W = 32;

  typedef enum logic {
    FUNC_ENQUEUE = 1'b0,
    FUNC_DEQUEUE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

// ===== rtl/core/circular_queue_min_max.sv =====
`timescale 1ns / 1ps
// Done strobes once the min/max scan has finished; the scan reads one entry
// per cycle from the store's single read port. A new request is taken only
// after the previous one has strobed done, as busy stays high until then.
// Results cannot be stalled. Reset (synchronous) empties the queue; store
// contents are kept.
// ----------------------------------------------------------------------------
// circular_queue_min_max
// Circular FIFO of signed words held in a synchronous RAM; each request is an
// enqueue or a dequeue and returns status, popped value, count and min/max.
// ----------------------------------------------------------------------------
module circular_queue_min_max
  import cqmm_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  localparam int IDX_W = $clog2(QUEUE_DEPTH),
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     func,
  input  logic signed [DATA_W-1:0] data_value,
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] popped_value,
  output logic [CNT_W-1:0]         entry_count,
  output logic                     is_empty,
  output logic signed [DATA_W-1:0] least_value,
  output logic signed [DATA_W-1:0] greatest_value
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  state_t state;

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] held_count;

  func_t                     req_func;
  logic signed [DATA_W-1:0]  req_data;
  status_t                   req_status;

  logic [IDX_W-1:0] scan_pos;
  logic [CNT_W-1:0] scan_left;
  logic             scan_first;

  logic                     rd_vld;
  logic                     rd_pop;
  logic signed [DATA_W-1:0] rd_data;

  logic signed [DATA_W-1:0] lo;
  logic signed [DATA_W-1:0] hi;
  logic signed [DATA_W-1:0] popped;

  logic             enq_ok;
  logic             deq_ok;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_next;
  logic [CNT_W-1:0] count_next;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign busy = (state != S_IDLE);

  always_comb begin
    enq_ok     = (req_func == FUNC_ENQUEUE) && (held_count != FULL_CNT);
    deq_ok     = (req_func == FUNC_DEQUEUE) && (held_count != '0);
    head_next  = deq_ok ? wrap_inc(head) : head;
    tail_next  = enq_ok ? wrap_inc(tail) : tail;
    count_next = enq_ok ? held_count + 1'b1 : (deq_ok ? held_count - 1'b1 : held_count);
    wr_en      = (state == S_EXEC) && enq_ok;
    rd_en      = ((state == S_EXEC) && deq_ok) || ((state == S_SCAN) && (scan_left != '0));
    rd_addr    = (state == S_EXEC) ? head : scan_pos;
  end

  // single-port store: write at tail, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= req_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      head       <= '0;
      tail       <= '0;
      held_count <= '0;
      rd_vld     <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= rd_en;
      rd_pop <= (state == S_EXEC);
      case (state)
        S_IDLE: begin
          if (start) begin
            req_func <= func_t'(func);
            req_data <= data_value;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          head       <= head_next;
          tail       <= tail_next;
          held_count <= count_next;
          scan_pos   <= head_next;
          scan_left  <= count_next;
          scan_first <= 1'b1;
          popped     <= '0;
          if (req_func == FUNC_ENQUEUE) begin
            req_status <= enq_ok ? ST_OK : ST_OVERFLOW;
          end else begin
            req_status <= deq_ok ? ST_OK : ST_UNDERFLOW;
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_left != '0) begin
            scan_pos  <= wrap_inc(scan_pos);
            scan_left <= scan_left - 1'b1;
          end
          if (rd_vld) begin
            if (rd_pop) begin
              popped <= rd_data;
            end else begin
              scan_first <= 1'b0;
              if (scan_first || (rd_data < lo)) begin
                lo <= rd_data;
              end
              if (scan_first || (rd_data > hi)) begin
                hi <= rd_data;
              end
            end
          end else if (scan_left == '0) begin
            done           <= 1'b1;
            status         <= req_status;
            popped_value   <= popped;
            entry_count    <= held_count;
            is_empty       <= (held_count == '0);
            least_value    <= (held_count == '0) ? '1 : lo;
            greatest_value <= (held_count == '0) ? '1 : hi;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= FULL_CNT)
    else $error("held count beyond depth");
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_OVERFLOW)) |-> (entry_count == FULL_CNT))
    else $error("overflow reported on non-full queue");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule

// ===== test/tb_circular_queue_min_max.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_queue_min_max
// Drives enqueue and dequeue requests into the circular queue. A short
// scripted sequence comes first: underflow, extreme values, a full queue with
// overflow, a full drain and index wrap. Biased random fill/drain traffic
// follows, under three sender idle profiles. Each strobed result is compared
// field by field against the in-bench queue model or fixed scripted values.
// ----------------------------------------------------------------------------
module tb_circular_queue_min_max;
  import cqmm_pkg::*;

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7fff_ffff;
  localparam int RANDOM_PER_PHASE = 275;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] popped;
    logic [CNT_W-1:0]         count;
    logic                     empty;
    logic signed [DATA_W-1:0] least;
    logic signed [DATA_W-1:0] greatest;
  } result_t;

  typedef struct {
    func_t                    op;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    result_t                  want;
  } row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  func_t                    func = FUNC_ENQUEUE;
  logic signed [DATA_W-1:0] data_value = '0;
  logic                     done;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] popped_value;
  logic [CNT_W-1:0]         entry_count;
  logic                     is_empty;
  logic signed [DATA_W-1:0] least_value;
  logic signed [DATA_W-1:0] greatest_value;

  logic signed [DATA_W-1:0] slot [DEPTH];
  int                       head_idx = 0;
  int                       tail_idx = 0;
  int                       held = 0;

  result_t                  pending_q [$];
  result_t                  oldest;
  row_t                     script [$];
  int                       errors = 0;
  bit                       filling = 1'b1;

  circular_queue_min_max #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .data_value    (data_value),
    .done          (done),
    .status        (status),
    .popped_value  (popped_value),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .least_value   (least_value),
    .greatest_value(greatest_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Advance the queue model by one request and return the result it yields.
  function automatic result_t apply_request(func_t op, logic signed [DATA_W-1:0] v);
    result_t                  r;
    int                       pos;
    logic signed [DATA_W-1:0] w;
    r.status = ST_OK;
    r.popped = '0;
    if (op == FUNC_ENQUEUE) begin
      if (held >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        slot[tail_idx] = v;
        tail_idx = (tail_idx + 1) % DEPTH;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.popped = slot[head_idx];
        head_idx = (head_idx + 1) % DEPTH;
        held--;
      end
    end
    r.count = CNT_W'(held);
    r.empty = (held == 0);
    r.least = -1;
    r.greatest = -1;
    pos = head_idx;
    for (int k = 0; k < held; k++) begin
      w = slot[pos];
      if (k == 0 || w < r.least) r.least = w;
      if (k == 0 || w > r.greatest) r.greatest = w;
      pos = (pos + 1) % DEPTH;
    end
    return r;
  endfunction

  function automatic row_t row(func_t op, logic signed [DATA_W-1:0] value, bit typed = 1'b0,
                               status_t st = ST_OK, int cnt = 0, bit emp = 1'b0,
                               logic signed [DATA_W-1:0] lo = 0,
                               logic signed [DATA_W-1:0] hi = 0);
    row_t r;
    r.op = op;
    r.value = value;
    r.typed = typed;
    r.want.status = st;
    r.want.popped = '0;
    r.want.count = CNT_W'(cnt);
    r.want.empty = emp;
    r.want.least = lo;
    r.want.greatest = hi;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return MIN_WORD;
      1: return MAX_WORD;
      2: return 0;
      3: return -1;
      4: return $signed($urandom_range(0, 20)) - 10;
      default: return $signed($urandom);
    endcase
  endfunction

  // Hold the request until accepted, then queue the expected result.
  task automatic issue(func_t op, logic signed [DATA_W-1:0] v, bit typed, result_t fixed);
    result_t r;
    start <= 1'b1;
    func <= op;
    data_value <= v;
    do @(posedge clk); while (busy);
    r = apply_request(op, v);
    pending_q.push_back(typed ? fixed : r);
  endtask

  task automatic pause(int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, DEPTH + 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        oldest = pending_q.pop_front();
        if (status !== oldest.status)
          report($sformatf("status %0d, want %0d", status, oldest.status));
        if (popped_value !== oldest.popped)
          report($sformatf("popped_value %0d, want %0d", popped_value, oldest.popped));
        if (entry_count !== oldest.count)
          report($sformatf("entry_count %0d, want %0d", entry_count, oldest.count));
        if (is_empty !== oldest.empty)
          report($sformatf("is_empty %0d, want %0d", is_empty, oldest.empty));
        if (least_value !== oldest.least)
          report($sformatf("least_value %0d, want %0d", least_value, oldest.least));
        if (greatest_value !== oldest.greatest)
          report($sformatf("greatest_value %0d, want %0d", greatest_value, oldest.greatest));
      end
    end
  end

  initial begin
    func_t op;
    int    idle_pct [3];
    idle_pct = '{27, 76, 0};

    script.push_back(row(FUNC_DEQUEUE, 0, 1, ST_UNDERFLOW, 0, 1, -1, -1));
    script.push_back(row(FUNC_ENQUEUE, MIN_WORD, 1, ST_OK, 1, 0, MIN_WORD, MIN_WORD));
    script.push_back(row(FUNC_ENQUEUE, MAX_WORD, 1, ST_OK, 2, 0, MIN_WORD, MAX_WORD));
    script.push_back(row(FUNC_ENQUEUE, 0));
    script.push_back(row(FUNC_ENQUEUE, -1));
    script.push_back(row(FUNC_ENQUEUE, 1));
    script.push_back(row(FUNC_ENQUEUE, 32'sh5555_5555));
    script.push_back(row(FUNC_ENQUEUE, 32'shaaaa_aaaa));
    script.push_back(row(FUNC_ENQUEUE, 7));
    script.push_back(row(FUNC_ENQUEUE, 123, 1, ST_OVERFLOW, DEPTH, 0, MIN_WORD, MAX_WORD));
    repeat (DEPTH) script.push_back(row(FUNC_DEQUEUE, 32'shffff_ffff));
    script.push_back(row(FUNC_DEQUEUE, 0, 1, ST_UNDERFLOW, 0, 1, -1, -1));
    script.push_back(row(FUNC_ENQUEUE, 5));
    script.push_back(row(FUNC_ENQUEUE, -5));
    script.push_back(row(FUNC_DEQUEUE, 0));
    script.push_back(row(FUNC_ENQUEUE, 42));
    script.push_back(row(FUNC_DEQUEUE, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      issue(script[i].op, script[i].value, script[i].typed, script[i].want);
      pause(10);
    end

    // Fill/drain bursts; flip direction at the ends and now and then.
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ((filling && held == DEPTH && $urandom_range(0, 2) == 0) ||
            (!filling && held == 0 && $urandom_range(0, 2) == 0) ||
            $urandom_range(0, 15) == 0)
          filling = !filling;
        if ($urandom_range(0, 9) == 0)
          op = $urandom_range(0, 1) ? FUNC_DEQUEUE : FUNC_ENQUEUE;
        else if ($urandom_range(0, 99) < 80)
          op = filling ? FUNC_ENQUEUE : FUNC_DEQUEUE;
        else
          op = filling ? FUNC_DEQUEUE : FUNC_ENQUEUE;
        issue(op, pick_value(), 1'b0, oldest);
        pause(idle_pct[ph]);
      end
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
